// ===== src/edge_table_pulse_generator_assert.svh =====
// ----------------------------------------------------------------------------
// Edge table pulse generator assertion macros
// Immediate-implication and next-cycle-implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef EDGE_TABLE_PULSE_GENERATOR_ASSERT_SVH
`define EDGE_TABLE_PULSE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define ETPG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("etpg: property failed");

// next-cycle implication
`define ETPG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("etpg: property failed");

`endif

// ===== src/etpg_pkg.sv =====
// ----------------------------------------------------------------------------
// etpg_pkg
// Shared types and constants of the edge table pulse generator.
// ----------------------------------------------------------------------------
package etpg_pkg;

   localparam int DEF_EDGE_SLOTS = 16;
   localparam int DEF_TIME_BITS  = 32;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD     = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INIT_LEVEL = 1'd1;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] edge_time;
      logic        edge_level;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic edge_fired;
      logic write_dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT_TICK,
      OP_ACCEPT_WRITE,
      OP_FIRE_A,
      OP_FIRE_B,
      OP_ARM_ADD,
      OP_ARM_CMP,
      OP_REARM,
      OP_ZERO_ONE,
      OP_ZERO_TWO,
      OP_SCAN_NEXT,
      OP_DECIDE,
      OP_WRITE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic fire_stop;
      logic cnt_zero;
      logic cnt_one;
      logic now_zero;
      logic armed_at_one;
      logic now_lt_start;
      logic idx_at_cnt;
      logic scan_gt;
      logic ws_ge;
      logic decide_stop;
   } dp_status_type;

endpackage

// ===== src/etpg_datapath.sv =====
// ----------------------------------------------------------------------------
// etpg_datapath
// Edge table, cycle counters, arming registers and result register.
// ----------------------------------------------------------------------------
module etpg_datapath #(
   parameter int EDGE_SLOTS = etpg_pkg::DEF_EDGE_SLOTS,
   parameter int TIME_BITS  = etpg_pkg::DEF_TIME_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  etpg_pkg::req_type                     req_data,
   input  logic                                  csr_we,
   input  logic [etpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [etpg_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  etpg_pkg::dp_cmd_type                  cmd,
   output etpg_pkg::dp_status_type               status,
   output etpg_pkg::rsp_type                     rsp_data
);
   import etpg_pkg::*;

   localparam int CW = $clog2(EDGE_SLOTS + 1);
   localparam int IW = $clog2(EDGE_SLOTS);

   logic [TIME_BITS-1:0] times_ff [EDGE_SLOTS];
   logic [TIME_BITS-1:0] times_in [EDGE_SLOTS];
   logic                 levels_ff [EDGE_SLOTS];
   logic                 levels_in [EDGE_SLOTS];

   logic [CW-1:0]        count_ff, count_in;
   logic [IW-1:0]        ni_ff, ni_in;
   logic                 armed_ff, armed_in;
   logic [63:0]          target_ff, target_in;
   logic [63:0]          start_ff, start_in;
   logic [63:0]          now_ff, now_in;
   logic                 level_ff, level_in;
   logic [31:0]          period_ff, period_in;
   logic                 init_ff, init_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [63:0]          sum_ff, sum_in;
   logic [63:0]          rel_ff, rel_in;
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic                 lv_ff, lv_in;
   logic                 fired_ff, fired_in;
   logic                 drop_ff, drop_in;
   rsp_type              out_ff, out_in;
   logic [TIME_BITS-1:0] rd_time_ff;
   logic                 rd_level_ff;

   logic [IW-1:0]        rd_addr;
   logic [63:0]          now_plus;
   logic [CW-1:0]        ni_plus;
   logic [CW-1:0]        pend;
   logic                 restart;
   logic                 eq_hit;

   assign now_plus = now_ff + 64'd1;
   assign ni_plus  = CW'(ni_ff) + CW'(1);
   assign pend     = armed_ff ? CW'(ni_ff) : count_ff;
   assign restart  = (period_ff != 32'd0) &&
                     ((idx_ff >= count_ff) || (64'(rd_time_ff) > 64'(period_ff)));
   assign eq_hit   = (idx_ff < count_ff) && (rd_time_ff == t_ff);

   always_comb begin
      status.hit          = armed_ff && (now_plus == target_ff);
      status.fire_stop    = (ni_plus >= count_ff) && (period_ff == 32'd0);
      status.cnt_zero     = (count_ff == '0);
      status.cnt_one      = (count_ff == CW'(1));
      status.now_zero     = (now_ff == 64'd0);
      status.armed_at_one = armed_ff && (ni_ff == IW'(1));
      status.now_lt_start = (now_ff < start_ff);
      status.idx_at_cnt   = (idx_ff == count_ff);
      status.scan_gt      = (64'(rd_time_ff) > rel_ff);
      status.ws_ge        = (rd_time_ff >= t_ff);
      status.decide_stop  = (idx_ff == pend) || (idx_ff >= count_ff);
   end

   always_comb begin
      times_in  = times_ff;
      levels_in = levels_ff;
      count_in  = count_ff;
      ni_in     = ni_ff;
      armed_in  = armed_ff;
      target_in = target_ff;
      start_in  = start_ff;
      now_in    = now_ff;
      level_in  = level_ff;
      period_in = period_ff;
      init_in   = init_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      rel_in    = rel_ff;
      t_in      = t_ff;
      lv_in     = lv_ff;
      fired_in  = fired_ff;
      drop_in   = drop_ff;
      out_in    = out_ff;
      rd_addr   = idx_ff[IW-1:0];

      case (cmd.op)
         OP_ACCEPT_TICK: begin
            now_in   = now_plus;
            fired_in = 1'b0;
            drop_in  = 1'b0;
            rd_addr  = ni_ff;
         end
         OP_ACCEPT_WRITE: begin
            t_in     = TIME_BITS'(req_data.edge_time);
            lv_in    = req_data.edge_level;
            idx_in   = '0;
            fired_in = 1'b0;
            drop_in  = 1'b0;
            rd_addr  = '0;
         end
         OP_FIRE_A: begin
            level_in = rd_level_ff;
            fired_in = 1'b1;
            ni_in    = ni_plus[IW-1:0];
            idx_in   = ni_plus;
            rd_addr  = ni_plus[IW-1:0];
            if (status.fire_stop) begin
               armed_in = 1'b0;
            end
         end
         OP_FIRE_B: begin
            if (restart) begin
               ni_in    = '0;
               idx_in   = '0;
               start_in = start_ff + 64'(period_ff);
               rd_addr  = '0;
            end
         end
         OP_ARM_ADD: begin
            sum_in = start_ff + 64'(rd_time_ff);
         end
         OP_ARM_CMP: begin
            if (sum_ff > now_ff) begin
               armed_in  = 1'b1;
               target_in = sum_ff;
               ni_in     = idx_ff[IW-1:0];
            end else begin
               armed_in = 1'b0;
            end
         end
         OP_REARM: begin
            if (status.cnt_zero) begin
               level_in = init_ff;
            end
            rel_in  = now_ff - start_ff;
            idx_in  = '0;
            rd_addr = '0;
         end
         OP_ZERO_ONE: begin
            level_in = rd_level_ff;
            armed_in = 1'b0;
         end
         OP_ZERO_TWO: begin
            level_in = rd_level_ff;
            idx_in   = CW'(1);
            rd_addr  = IW'(1);
         end
         OP_SCAN_NEXT: begin
            idx_in = idx_ff + CW'(1);
         end
         OP_DECIDE: begin
            if ((idx_ff != pend) && (idx_ff >= count_ff)) begin
               armed_in = 1'b0;
            end
         end
         OP_WRITE: begin
            if (eq_hit) begin
               levels_in[idx_ff[IW-1:0]] = lv_ff;
            end else if (count_ff >= CW'(EDGE_SLOTS)) begin
               drop_in = 1'b1;
            end else begin
               for (int j = 0; j < EDGE_SLOTS; j++) begin
                  if (CW'(j) == idx_ff) begin
                     times_in[j]  = t_ff;
                     levels_in[j] = lv_ff;
                  end else if ((j > 0) && (CW'(j) > idx_ff)) begin
                     times_in[j]  = times_ff[(j > 0) ? j - 1 : 0];
                     levels_in[j] = levels_ff[(j > 0) ? j - 1 : 0];
                  end
               end
               count_in = count_ff + CW'(1);
               if (armed_ff && (idx_ff <= CW'(ni_ff))) begin
                  ni_in = ni_ff + IW'(1);
               end
            end
         end
         default: begin
         end
      endcase

      if (cmd.emit) begin
         if (cmd.op == OP_ACCEPT_TICK) begin
            out_in = '{pin_level: level_ff, edge_fired: 1'b0, write_dropped: 1'b0};
         end else begin
            out_in = '{pin_level: level_ff, edge_fired: fired_ff, write_dropped: drop_ff};
         end
      end

      if (csr_we) begin
         case (csr_index)
            CSR_PERIOD:     period_in = csr_wdata;
            CSR_INIT_LEVEL: init_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ni_ff     <= '0;
         armed_ff  <= 1'b0;
         target_ff <= '0;
         start_ff  <= '0;
         now_ff    <= '0;
         level_ff  <= 1'b1;
         period_ff <= '0;
         init_ff   <= 1'b1;
      end else begin
         count_ff  <= count_in;
         ni_ff     <= ni_in;
         armed_ff  <= armed_in;
         target_ff <= target_in;
         start_ff  <= start_in;
         now_ff    <= now_in;
         level_ff  <= level_in;
         period_ff <= period_in;
         init_ff   <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      times_ff    <= times_in;
      levels_ff   <= levels_in;
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      rel_ff      <= rel_in;
      t_ff        <= t_in;
      lv_ff       <= lv_in;
      fired_ff    <= fired_in;
      drop_ff     <= drop_in;
      out_ff      <= out_in;
      rd_time_ff  <= times_ff[rd_addr];
      rd_level_ff <= levels_ff[rd_addr];
   end

   assign rsp_data = out_ff;

endmodule

// ===== src/etpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// etpg_ctrl
// Sequencer for ticks, edge writes, rearm search and result delivery.
// ----------------------------------------------------------------------------
module etpg_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                csr_we,
   input  logic [etpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  etpg_pkg::dp_status_type             status,
   output etpg_pkg::dp_cmd_type                cmd
);
   import etpg_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_FIRE_A   = 15'b000000000000010,
      ST_FIRE_B   = 15'b000000000000100,
      ST_ARM_ADD  = 15'b000000000001000,
      ST_ARM_CMP  = 15'b000000000010000,
      ST_REARM    = 15'b000000000100000,
      ST_ZERO_ONE = 15'b000000001000000,
      ST_ZERO_TWO = 15'b000000010000000,
      ST_SCAN_RD  = 15'b000000100000000,
      ST_SCAN_CHK = 15'b000001000000000,
      ST_DECIDE   = 15'b000010000000000,
      ST_WS_RD    = 15'b000100000000000,
      ST_WS_CHK   = 15'b001000000000000,
      ST_WS_DO    = 15'b010000000000000,
      ST_FINISH   = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      from_cfg_ff, from_cfg_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      cfg_rearm;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cfg_rearm = csr_we && (csr_index == CSR_INIT_LEVEL);
   assign req_stall = (state_ff != ST_IDLE) || cfg_rearm;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      from_cfg_in = from_cfg_ff;
      cmd.op      = OP_NONE;
      cmd.emit    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cfg_rearm) begin
               from_cfg_in = 1'b1;
               state_in    = ST_REARM;
            end else if (req_valid) begin
               from_cfg_in = 1'b0;
               if (req_mode == MODE_TICK) begin
                  cmd.op = OP_ACCEPT_TICK;
                  if (status.hit) begin
                     state_in = ST_FIRE_A;
                  end else if (out_free) begin
                     cmd.emit = 1'b1;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  cmd.op   = OP_ACCEPT_WRITE;
                  state_in = ST_WS_RD;
               end
            end
         end
         ST_FIRE_A: begin
            cmd.op   = OP_FIRE_A;
            state_in = status.fire_stop ? ST_FINISH : ST_FIRE_B;
         end
         ST_FIRE_B: begin
            cmd.op   = OP_FIRE_B;
            state_in = ST_ARM_ADD;
         end
         ST_ARM_ADD: begin
            cmd.op   = OP_ARM_ADD;
            state_in = ST_ARM_CMP;
         end
         ST_ARM_CMP: begin
            cmd.op   = OP_ARM_CMP;
            state_in = ST_FINISH;
         end
         ST_REARM: begin
            cmd.op = OP_REARM;
            if (status.cnt_zero) begin
               state_in = ST_FINISH;
            end else if (status.now_zero) begin
               if (status.cnt_one) begin
                  state_in = ST_ZERO_ONE;
               end else if (status.armed_at_one) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ZERO_TWO;
               end
            end else if (status.now_lt_start) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_ZERO_ONE: begin
            cmd.op   = OP_ZERO_ONE;
            state_in = ST_FINISH;
         end
         ST_ZERO_TWO: begin
            cmd.op   = OP_ZERO_TWO;
            state_in = ST_ARM_ADD;
         end
         ST_SCAN_RD: begin
            state_in = status.idx_at_cnt ? ST_DECIDE : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (status.scan_gt) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.op   = OP_SCAN_NEXT;
               state_in = ST_SCAN_RD;
            end
         end
         ST_DECIDE: begin
            cmd.op   = OP_DECIDE;
            state_in = status.decide_stop ? ST_FINISH : ST_ARM_ADD;
         end
         ST_WS_RD: begin
            state_in = status.idx_at_cnt ? ST_WS_DO : ST_WS_CHK;
         end
         ST_WS_CHK: begin
            if (status.ws_ge) begin
               state_in = ST_WS_DO;
            end else begin
               cmd.op   = OP_SCAN_NEXT;
               state_in = ST_WS_RD;
            end
         end
         ST_WS_DO: begin
            cmd.op   = OP_WRITE;
            state_in = ST_REARM;
         end
         ST_FINISH: begin
            if (from_cfg_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         from_cfg_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         from_cfg_ff  <= from_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/edge_table_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// edge_table_pulse_generator
// Drives one pin level from a sorted table of timed edges.
// ----------------------------------------------------------------------------
// A tick transaction with no edge due is answered from idle when the result
// register is free, and the next one can then be accepted in the following
// cycle. A tick that fires an edge steps through accept, level update, restart
// check, 64-bit target add, target compare and result; the last edge of a
// one-shot waveform goes from the level update straight to the result. An
// edge write walks the table up to twice through a single registered read
// port. A write of initial_level starts the same next-edge search and holds
// off transactions until it is done. One result per transaction.
// ----------------------------------------------------------------------------
module edge_table_pulse_generator #(
   parameter int EDGE_SLOTS = etpg_pkg::DEF_EDGE_SLOTS,
   parameter int TIME_BITS  = etpg_pkg::DEF_TIME_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  etpg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output etpg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [etpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [etpg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import etpg_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   etpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .status    (status),
      .cmd       (cmd)
   );

   etpg_datapath #(
      .EDGE_SLOTS (EDGE_SLOTS),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/etpg_checker.sv =====
// ----------------------------------------------------------------------------
// etpg_checker
// Port-level checks of the edge table pulse generator, bound to the top.
// ----------------------------------------------------------------------------
`include "edge_table_pulse_generator_assert.svh"

module etpg_port_props (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input etpg_pkg::req_type                   req_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input etpg_pkg::rsp_type                   rsp_data,
   input logic                                csr_we,
   input logic [etpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [etpg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import etpg_pkg::*;

   `ETPG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ETPG_ASSERT_IMP(a_fire_drop_excl, clock, reset, rsp_valid, !(rsp_data.edge_fired && rsp_data.write_dropped))
   `ETPG_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind edge_table_pulse_generator etpg_port_props u_etpg_port_props (.*);

// ===== dv/etpg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etpg_checker
// Watches the request, result and CSR ports of the edge table pulse
// generator, tracks the edge table and pin state itself, and compares every
// result transaction with the predicted pin level, fire and drop flags.
// ----------------------------------------------------------------------------
module etpg_checker
   import etpg_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   localparam int SLOTS = DEF_EDGE_SLOTS;

   logic [31:0] tbl_time [SLOTS];
   logic        tbl_level [SLOTS];
   int          tbl_count;
   int          nxt;
   logic        armed;
   logic [63:0] target_cyc;
   logic [63:0] start_cyc;
   logic [63:0] now_cyc;
   logic        pin;
   logic [31:0] period;
   logic        init_level;

   rsp_type     pin_queue[$];

   assign pending = pin_queue.size();

   function automatic void arm_at(logic [63:0] when, int idx);
      armed = 1'b0;
      if (when > now_cyc) begin
         armed      = 1'b1;
         target_cyc = when;
         nxt        = idx;
      end
   endfunction

   function automatic void find_next_edge();
      int          i;
      logic [63:0] rel;
      if (tbl_count == 0) begin
         pin = init_level;
         return;
      end
      if (now_cyc == 0) begin
         if (tbl_count == 1) begin
            pin   = tbl_level[0];
            armed = 1'b0;
            return;
         end
         if (armed && nxt == 1) return;
         pin = tbl_level[0];
         arm_at({32'd0, tbl_time[1]}, 1);
         return;
      end
      if (now_cyc < start_cyc) begin
         i = 0;
      end else begin
         rel = now_cyc - start_cyc;
         for (i = 0; i < tbl_count; i++)
            if ({32'd0, tbl_time[i]} > rel) break;
      end
      if (i == (armed ? nxt : tbl_count)) return;
      if (i >= tbl_count) begin
         armed = 1'b0;
         return;
      end
      arm_at(start_cyc + tbl_time[i], i);
   endfunction

   function automatic void fire_edge();
      logic [63:0] t;
      pin = tbl_level[nxt % SLOTS];
      nxt++;
      if (nxt >= tbl_count && period == 0) begin
         armed = 1'b0;
         return;
      end
      if (period != 0 && (nxt >= tbl_count || tbl_time[nxt] > period)) begin
         nxt       = 0;
         start_cyc = start_cyc + period;
      end
      t = start_cyc + tbl_time[nxt];
      if (t > now_cyc) target_cyc = t;
      else armed = 1'b0;
   endfunction

   function automatic rsp_type predict_pin(req_type r);
      rsp_type res;
      int      i;
      int      pos;
      res = '0;
      if (r.mode == MODE_TICK) begin
         now_cyc = now_cyc + 1;
         if (armed && now_cyc == target_cyc) begin
            fire_edge();
            res.edge_fired = 1'b1;
         end
      end else begin
         for (i = 0; i < tbl_count; i++)
            if (tbl_time[i] == r.edge_time) break;
         if (i < tbl_count) begin
            tbl_level[i] = r.edge_level;
         end else if (tbl_count >= SLOTS) begin
            res.write_dropped = 1'b1;
         end else begin
            for (pos = 0; pos < tbl_count; pos++)
               if (tbl_time[pos] > r.edge_time) break;
            for (i = tbl_count; i > pos; i--) begin
               tbl_time[i]  = tbl_time[i-1];
               tbl_level[i] = tbl_level[i-1];
            end
            tbl_time[pos]  = r.edge_time;
            tbl_level[pos] = r.edge_level;
            tbl_count++;
            if (armed && pos <= nxt) nxt++;
         end
         find_next_edge();
      end
      res.pin_level = pin;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_pin;
      rsp_type new_pin;
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            tbl_time[k]  = '0;
            tbl_level[k] = 1'b0;
         end
         tbl_count  = 0;
         nxt        = 0;
         armed      = 1'b0;
         target_cyc = '0;
         start_cyc  = '0;
         now_cyc    = '0;
         period     = '0;
         init_level = 1'b1;
         pin        = 1'b1;
         pin_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pin_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result transaction %p", $realtime, rsp_data);
            end else begin
               exp_pin = pin_queue.pop_front();
               if (rsp_data.pin_level !== exp_pin.pin_level ||
                   rsp_data.edge_fired !== exp_pin.edge_fired ||
                   rsp_data.write_dropped !== exp_pin.write_dropped) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch expected %p actual %p",
                              $realtime, exp_pin, rsp_data);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_PERIOD) begin
               period = csr_wdata;
            end else begin
               init_level = csr_wdata[0];
               find_next_edge();
            end
         end
         if (req_valid && !req_stall) begin
            new_pin   = predict_pin(req_data);
            pin_queue = {pin_queue, new_pin};
         end
      end
   end

endmodule

// ===== dv/tb_edge_table_pulse_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_table_pulse_generator
// Drives tick and edge write transactions with random gaps and result stalls,
// reprograms period and initial level between phases, and reports the
// verdict from the checker's failure count or a no-progress watchdog.
// ----------------------------------------------------------------------------
module tb_edge_table_pulse_generator;
   import etpg_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;
   int                        fail_count;
   int                        pending;
   logic                      hold_long;
   int                        quiet_cycles;

   edge_table_pulse_generator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   etpg_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stall before each transaction, one long hold on request
   initial begin
      int w;
      rsp_stall = 1'b1;
      hold_long = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
         if (hold_long) begin
            w = 300;
            hold_long = 1'b0;
         end
         repeat (w) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending == 0 && !req_valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send(req_type item, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type tick_item();
      req_type r;
      r.mode       = MODE_TICK;
      r.edge_time  = $urandom;
      r.edge_level = $urandom_range(0, 1);
      return r;
   endfunction

   function automatic req_type edge_item(logic [31:0] t, logic lv);
      req_type r;
      r.mode       = MODE_WRITE;
      r.edge_time  = t;
      r.edge_level = lv;
      return r;
   endfunction

   function automatic req_type random_item();
      logic [31:0] t;
      if ($urandom_range(0, 99) < 65) return tick_item();
      t = $urandom_range(0, 99) < 6 ? $urandom : $urandom_range(0, 50);
      return edge_item(t, $urandom_range(0, 1));
   endfunction

   initial begin
      logic [31:0] periods [8];
      bit          burst;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_PERIOD;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // table writes while the cycle count is still zero
      send(edge_item(32'd4, 1'b0), 0);
      drain();
      write_reg(CSR_INIT_LEVEL, 32'd0);
      drain();
      send(edge_item(32'd0, 1'b0), 0);
      send(edge_item(32'd2, 1'b1), 0);
      send(edge_item(32'd2, 1'b0), 0);
      send(edge_item(32'hFFFF_FFFF, 1'b1), 0);
      drain();
      write_reg(CSR_INIT_LEVEL, 32'hFFFF_FFFF);
      write_reg(CSR_PERIOD, 32'd0);
      repeat (6) send(tick_item(), 0);
      send(edge_item(32'd1, 1'b1), 0);
      send(edge_item(32'd9, 1'b1), 0);
      repeat (6) send(tick_item(), 1);
      send(edge_item(32'h8000_0000, 1'b0), 0);
      drain();

      periods = '{32'd20, 32'd0, 32'd45, 32'hFFFF_FFFF, 32'd8, 32'd0, 32'd30, 32'd1};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_PERIOD, periods[ph] == 32'd1 ? $urandom_range(1, 100) : periods[ph]);
         write_reg(CSR_INIT_LEVEL, $urandom_range(0, 1));
         for (int n = 0; n < 155; n++) begin
            if (ph == 2 && n == 40) hold_long = 1'b1;
            if (ph == 4 && n == 70) drain();
            burst = (n / 20) % 3 == 1;
            send(random_item(), burst);
         end
         drain();
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/etpg_pkg.sv
src/etpg_datapath.sv
src/etpg_ctrl.sv
src/edge_table_pulse_generator.sv
src/etpg_checker.sv
dv/etpg_checker.sv
dv/tb_edge_table_pulse_generator.sv
